FILE: rtl/rpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_pkg: shared types and constants for the random permutation draw block
// Field widths, table entry layout, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int MAX_VALUES_DEF = 1024;
  localparam int COUNT_RESET    = 1024;

  localparam int CNT_W   = 11;  // value count, draw position, drawn_so_far
  localparam int OFF_W   = 10;  // random_offset
  localparam int VAL_W   = 10;  // drawn_value
  localparam int EV_W    = 11;  // stored value plus one, zero = own index
  localparam int EPOCH_W = 8;   // round tag kept beside each entry

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ERR,
    S_RD_R,
    S_RD_P,
    S_WR_R,
    S_WR_P
  } state_t;

  typedef struct packed {
    logic accept;     // latch the item and its decision
    logic epoch_inc;  // start a new round by bumping the tag
    logic clr_run;    // write one cleared entry of the sweep
    logic clr_end;    // sweep finished, tag back to its first value
    logic rd_r;       // read the entry at the drawn position
    logic rd_p;       // read the entry at the draw position
    logic wr_r;       // write the drawn position
    logic wr_p;       // write the draw position
    logic out_load;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic restart_now;
    logic err_now;
    logic epoch_max;
    logic clr_last;
    logic slot_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/rpd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/rpd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_ctrl: sequencing state machine
// Walks each draw through two table reads and two writes, runs the
// table clearing sweep and holds the result until the output is free.
// ----------------------------------------------------------------------------
module rpd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic          cfg_wr_en,
  input  wire rpd_pkg::sts_t sts,
  output rpd_pkg::cmd_t      cmd
);

  import rpd_pkg::*;

  state_t state_r, state_nxt;
  logic   resume_r, resume_nxt;  // an accepted draw waits for the sweep

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      resume_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      resume_r <= resume_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    resume_nxt = resume_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (sts.clr_last) begin
          cmd.clr_end = 1'b1;
          resume_nxt  = 1'b0;
          state_nxt   = resume_r ? S_RD_R : S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = !cfg_wr_en;
        if (cfg_wr_en) begin
          // tag space used up: sweep the table instead
          if (sts.epoch_max) begin
            state_nxt = S_CLEAR;
          end else begin
            cmd.epoch_inc = 1'b1;
          end
        end else if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.err_now) begin
            state_nxt = S_ERR;
          end else if (sts.restart_now && sts.epoch_max) begin
            resume_nxt = 1'b1;
            state_nxt  = S_CLEAR;
          end else begin
            cmd.epoch_inc = sts.restart_now;
            state_nxt     = S_RD_R;
          end
        end
      end
      S_ERR: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RD_R: begin
        cmd.rd_r  = 1'b1;
        state_nxt = S_RD_P;
      end
      S_RD_P: begin
        cmd.rd_p  = 1'b1;
        state_nxt = S_WR_R;
      end
      S_WR_R: begin
        cmd.wr_r  = 1'b1;
        state_nxt = S_WR_P;
      end
      S_WR_P: begin
        // rewriting the same entry while stalled is harmless
        cmd.wr_p = 1'b1;
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/rpd_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_dpath: draw datapath
// Count and position registers, draw decision, round tag, permutation
// table with clearing sweep counter, and the result register.
// ----------------------------------------------------------------------------
module rpd_dpath #(
  parameter int MAX_VALUES = rpd_pkg::MAX_VALUES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [rpd_pkg::OFF_W-1:0]   in_offset,
  input  wire logic                        cfg_wr_en,
  input  wire logic [rpd_pkg::CNT_W-1:0]   cfg_wr_data,
  input  wire rpd_pkg::cmd_t               cmd,
  output rpd_pkg::sts_t                    sts,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rpd_pkg::VAL_W-1:0]        out_value,
  output logic [rpd_pkg::CNT_W-1:0]        out_so_far,
  output logic                             out_restarted,
  output logic                             out_error
);

  import rpd_pkg::*;

  localparam int AW     = $clog2(MAX_VALUES);
  localparam int WORD_W = EPOCH_W + EV_W;
  localparam int CNT_RST_I = (COUNT_RESET > MAX_VALUES) ? MAX_VALUES : COUNT_RESET;
  localparam logic [CNT_W-1:0] CNT_RST = CNT_W'(CNT_RST_I);
  localparam logic [AW-1:0]    CLR_LAST = AW'(MAX_VALUES - 1);

  logic [CNT_W-1:0]   count_r, pos_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [AW-1:0]      clr_cnt_r;

  // item registers
  logic [CNT_W-1:0] pos_eff_r, r_pos_r;
  logic             restart_r, err_r;
  logic [EV_W-1:0]  a_r;

  // result register
  logic             out_valid_r;
  logic [VAL_W-1:0] value_r;
  logic [CNT_W-1:0] so_far_r;
  logic             restarted_r, oerr_r;

  logic [CNT_W-1:0] cfg_cnt;
  logic             restart_now, err_now;
  logic [CNT_W-1:0] pos_now, remain, r_now;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;
  logic [EV_W-1:0]   rd_val, a_val, b_val;
  logic              rd_hit;

  // register write, out-of-range counts saturated
  always_comb begin
    cfg_cnt = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      cfg_cnt = CNT_W'(1);
    end else if (int'(cfg_wr_data) > MAX_VALUES) begin
      cfg_cnt = CNT_W'(MAX_VALUES);
    end
  end

  // draw decision on the offset being offered
  always_comb begin
    restart_now = (pos_r >= count_r);
    pos_now     = restart_now ? '0 : pos_r;
    remain      = count_r - pos_now;
    err_now     = (CNT_W'(in_offset) >= remain);
    r_now       = pos_now + CNT_W'(in_offset);
  end

  // table entry decode: stale tag or zero means the entry holds its own index
  assign rd_val = rdata[EV_W-1:0];
  assign rd_hit = (rdata[WORD_W-1:EV_W] == epoch_r) && (rd_val != '0);
  assign a_val  = rd_hit ? rd_val : r_pos_r + CNT_W'(1);
  assign b_val  = rd_hit ? rd_val : pos_eff_r + CNT_W'(1);

  always_comb begin
    we    = 1'b0;
    waddr = AW'(pos_eff_r);
    wdata = {epoch_r, a_r};
    raddr = cmd.rd_r ? AW'(r_pos_r) : AW'(pos_eff_r);
    if (cmd.clr_run) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = '0;
    end else if (cmd.wr_r) begin
      we    = 1'b1;
      waddr = AW'(r_pos_r);
      wdata = {epoch_r, b_val};
    end else if (cmd.wr_p) begin
      we    = 1'b1;
    end
  end

  rpd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_VALUES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CNT_RST;
      pos_r       <= '0;
      epoch_r     <= EPOCH_W'(1);
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_cnt;
        pos_r   <= '0;
      end else if (cmd.out_load && !err_r) begin
        pos_r <= pos_eff_r + CNT_W'(1);
      end

      if (cmd.clr_end) begin
        epoch_r <= EPOCH_W'(1);
      end else if (cmd.epoch_inc) begin
        epoch_r <= epoch_r + EPOCH_W'(1);
      end

      if (cmd.clr_end) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_run) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_eff_r <= pos_now;
      r_pos_r   <= r_now;
      restart_r <= restart_now;
      err_r     <= err_now;
    end
    if (cmd.rd_p) begin
      a_r <= a_val;
    end
    if (cmd.out_load) begin
      if (err_r) begin
        value_r     <= '0;
        so_far_r    <= pos_r;
        restarted_r <= 1'b0;
        oerr_r      <= 1'b1;
      end else begin
        value_r     <= VAL_W'(a_r - EV_W'(1));
        so_far_r    <= pos_eff_r + CNT_W'(1);
        restarted_r <= restart_r;
        oerr_r      <= 1'b0;
      end
    end
  end

  assign sts.restart_now = restart_now;
  assign sts.err_now     = err_now;
  assign sts.epoch_max   = &epoch_r;
  assign sts.clr_last    = (clr_cnt_r == CLR_LAST);
  assign sts.slot_free   = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_value     = value_r;
  assign out_so_far    = so_far_r;
  assign out_restarted = restarted_r;
  assign out_error     = oerr_r;

endmodule
`default_nettype wire

FILE: rtl/random_permutation_draw.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencing: a draw's result is loaded after the input transfer passes through
// S_RD_R, S_RD_P, S_WR_R and S_WR_P, an offset error's after S_ERR; one item is
// in work at a time, and a draw's steps are set by the two reads and two writes
// on the table RAM's single read and single write port. A held result stalls.
// Reset: after rst_n the table is cleared by a sweep over all its entries with
// in_tready low; the same sweep runs on every 255th round restart or count write.
// ----------------------------------------------------------------------------
// random_permutation_draw: lazy Fisher-Yates permutation iterator
// Hands out 0..value_count-1 in random order, one value per in-range input offset,
// restoring the table lazily via a per-entry round tag.
// ----------------------------------------------------------------------------
module random_permutation_draw #(
  parameter int MAX_VALUES = rpd_pkg::MAX_VALUES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: [9:0] random_offset, [15:10] zero
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [rpd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: [9:0] drawn_value, [20:10] drawn_so_far, [23:21] zero
  // out_tuser: [0] round_restarted, [1] offset_error
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [rpd_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic [rpd_pkg::OUT_TUSER_W-1:0]         out_tuser,
  input  wire logic                               cfg_wr_en,
  input  wire logic [rpd_pkg::CNT_W-1:0]          cfg_wr_data
);

  import rpd_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [VAL_W-1:0] drawn_value;
  logic [CNT_W-1:0] drawn_so_far;
  logic             round_restarted, offset_error;

  rpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_wr_en (cfg_wr_en),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpd_dpath #(
    .MAX_VALUES (MAX_VALUES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_offset     (in_tdata[OFF_W-1:0]),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_value     (drawn_value),
    .out_so_far    (drawn_so_far),
    .out_restarted (round_restarted),
    .out_error     (offset_error)
  );

  assign out_tdata = {{(OUT_TDATA_W - VAL_W - CNT_W){1'b0}}, drawn_so_far, drawn_value};
  assign out_tuser = {offset_error, round_restarted};

endmodule
`default_nettype wire
